@@ src/hex_record_loader_core_defines.svh @@
// ----------------------------------------------------------------------------
// hex_record_loader_core_defines
// Assertion macros shared by the hex record loader RTL.
// ----------------------------------------------------------------------------
`ifndef HEX_RECORD_LOADER_CORE_DEFINES_SVH
`define HEX_RECORD_LOADER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HRL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hex record loader check failed");

// Next-cycle implication, disabled during reset.
`define HRL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hex record loader check failed");

`endif

@@ src/hrl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrl_pkg
// Types, constants and helpers of the hex record loader.
// ----------------------------------------------------------------------------
package hrl_pkg;

  localparam int unsigned WINDOW_BASE_DEF = 32768;
  localparam int unsigned MEM_SIZE_DEF    = 29184;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned ADDR_W = 17;

  // Holes in the load window, as offsets from the window base
  localparam logic [ADDR_W-1:0] HOLE1_LO = 17'h003B0;
  localparam logic [ADDR_W-1:0] HOLE1_HI = 17'h003D0;
  localparam logic [ADDR_W-1:0] HOLE2_LO = 17'h003E0;
  localparam logic [ADDR_W-1:0] HOLE2_HI = 17'h003FF;

  localparam logic [14:0] TRAILER_OFS = 15'h03EC;

  typedef struct packed {
    logic [7:0] text_char;
    logic       file_end;
  } in_item_t;

  typedef struct packed {
    logic [14:0] mem_offset;
    logic [7:0]  mem_data;
    logic        is_trailer;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    POS_LEAD  = 3'd0,
    POS_COUNT = 3'd1,
    POS_ADDR  = 3'd2,
    POS_TYPE  = 3'd3,
    POS_DATA  = 3'd4,
    POS_CSUM  = 3'd5,
    POS_EOL   = 3'd6
  } pos_t;

  typedef enum logic [0:0] {
    CMD_DATA    = 1'b0,
    CMD_TRAILER = 1'b1
  } cmd_kind_t;

  // Data: addr_a = offset, addr_b = byte. Trailer: addr_a = end, addr_b = start.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] addr_a;
    logic [15:0] addr_b;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'h0;
    if (c inside {[8'h30:8'h39]}) v = 4'(c - 8'h30);
    else if (c inside {[8'h41:8'h46]}) v = 4'(c - 8'h41 + 8'd10);
    else if (c inside {[8'h61:8'h66]}) v = 4'(c - 8'h61 + 8'd10);
    return v;
  endfunction

endpackage

@@ src/hrl_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrl_queue
// Short command queue between the record parser and the write emitter.
// ----------------------------------------------------------------------------
module hrl_queue #(
  parameter int unsigned DEPTH = hrl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hrl_pkg::cmd_t     push_cmd,
  input  logic              pop,
  output hrl_pkg::cmd_t     head_cmd,
  output hrl_pkg::q_status_t status
);
  import hrl_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign status.full  = (count_r == FULL_CNT);
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_cmd     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ src/hrl_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrl_front
// Record parser: steps through record fields and queues write commands.
// ----------------------------------------------------------------------------
module hrl_front #(
  parameter int unsigned WINDOW_BASE = hrl_pkg::WINDOW_BASE_DEF,
  parameter int unsigned MEM_SIZE    = hrl_pkg::MEM_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  hrl_pkg::in_item_t item,
  output logic              push,
  output hrl_pkg::cmd_t     push_cmd
);
  import hrl_pkg::*;

  localparam logic [ADDR_W-1:0] BASE17 = {1'b0, 16'(WINDOW_BASE)};
  localparam logic [ADDR_W-1:0] SIZE17 = ADDR_W'(MEM_SIZE);

  pos_t              pos_r, pos_nxt;
  logic [1:0]        dcnt_r, dcnt_nxt;
  logic [7:0]        remain_r, remain_nxt;
  logic [ADDR_W-1:0] rec_r, rec_nxt;
  logic [15:0]       start_r, start_nxt;
  logic [3:0]        hnib_r, hnib_nxt;
  logic              done_r, done_nxt;

  logic [3:0]        nib;
  logic [7:0]        pair;
  logic [ADDR_W-1:0] rec_shift, rec_m1, ofs;
  logic              in_win;
  cmd_t              trailer_cmd;

  assign nib       = hex_value(item.text_char);
  assign pair      = {hnib_r, nib};
  assign rec_shift = {rec_r[ADDR_W-5:0], nib};
  assign rec_m1    = rec_r - 1'b1;
  assign ofs       = rec_r - BASE17;

  always_comb begin
    in_win = (rec_r >= BASE17) && (ofs < SIZE17);
    if (ofs inside {[HOLE1_LO:HOLE1_HI]}) in_win = 1'b0;
    if (ofs inside {[HOLE2_LO:HOLE2_HI]}) in_win = 1'b0;
  end

  always_comb begin
    trailer_cmd.kind   = CMD_TRAILER;
    trailer_cmd.addr_a = rec_m1[15:0];
    trailer_cmd.addr_b = start_r;
  end

  always_comb begin
    pos_nxt    = pos_r;
    dcnt_nxt   = dcnt_r;
    remain_nxt = remain_r;
    rec_nxt    = rec_r;
    start_nxt  = start_r;
    hnib_nxt   = hnib_r;
    done_nxt   = done_r;
    push       = 1'b0;
    push_cmd   = trailer_cmd;
    if (accept) begin
      if (item.file_end) begin
        // Finish if still open, then rearm
        push       = !done_r;
        pos_nxt    = POS_LEAD;
        dcnt_nxt   = '0;
        remain_nxt = '0;
        rec_nxt    = '0;
        start_nxt  = '0;
        hnib_nxt   = '0;
        done_nxt   = 1'b0;
      end else if (!done_r) begin
        case (pos_r)
          POS_LEAD: begin
            pos_nxt  = POS_COUNT;
            dcnt_nxt = '0;
          end
          POS_COUNT: begin
            if (dcnt_r == 2'd0) begin
              hnib_nxt = nib;
              dcnt_nxt = 2'd1;
            end else begin
              remain_nxt = pair;
              dcnt_nxt   = '0;
              if (pair == 8'd0) begin
                push     = 1'b1;
                done_nxt = 1'b1;
              end else begin
                pos_nxt = POS_ADDR;
              end
            end
          end
          POS_ADDR: begin
            rec_nxt = (dcnt_r == 2'd0) ? ADDR_W'(nib) : rec_shift;
            if (dcnt_r == 2'd3) begin
              if (start_r == 16'd0) start_nxt = rec_nxt[15:0];
              dcnt_nxt = '0;
              pos_nxt  = POS_TYPE;
            end else begin
              dcnt_nxt = dcnt_r + 1'b1;
            end
          end
          POS_TYPE: begin
            if (dcnt_r == 2'd0) begin
              dcnt_nxt = 2'd1;
            end else begin
              dcnt_nxt = '0;
              pos_nxt  = (remain_r == 8'd0) ? POS_CSUM : POS_DATA;
            end
          end
          POS_DATA: begin
            if (dcnt_r == 2'd0) begin
              hnib_nxt = nib;
              dcnt_nxt = 2'd1;
            end else begin
              push            = in_win;
              push_cmd.kind   = CMD_DATA;
              push_cmd.addr_a = {1'b0, ofs[14:0]};
              push_cmd.addr_b = {8'h00, pair};
              rec_nxt         = rec_r + 1'b1;
              remain_nxt      = remain_r - 1'b1;
              dcnt_nxt        = '0;
              if (remain_nxt == 8'd0) pos_nxt = POS_CSUM;
            end
          end
          POS_CSUM: begin
            if (dcnt_r == 2'd0) begin
              dcnt_nxt = 2'd1;
            end else begin
              dcnt_nxt = '0;
              pos_nxt  = POS_EOL;
            end
          end
          POS_EOL: begin
            if (dcnt_r == 2'd0) begin
              dcnt_nxt = 2'd1;
            end else begin
              dcnt_nxt = '0;
              pos_nxt  = POS_LEAD;
            end
          end
          default: begin
            pos_nxt  = POS_LEAD;
            dcnt_nxt = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_LEAD;
      dcnt_r   <= '0;
      remain_r <= '0;
      rec_r    <= '0;
      start_r  <= '0;
      hnib_r   <= '0;
      done_r   <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      dcnt_r   <= dcnt_nxt;
      remain_r <= remain_nxt;
      rec_r    <= rec_nxt;
      start_r  <= start_nxt;
      hnib_r   <= hnib_nxt;
      done_r   <= done_nxt;
    end
  end

endmodule

@@ src/hrl_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrl_back
// Write emitter: turns queued commands into one data write or four trailer writes.
// ----------------------------------------------------------------------------
module hrl_back (
  input  logic                clk,
  input  logic                rst_n,
  input  hrl_pkg::cmd_t       head_cmd,
  input  hrl_pkg::q_status_t  status,
  input  logic                out_stall,
  output logic                out_valid,
  output hrl_pkg::out_item_t  out_data,
  output logic                pop
);
  import hrl_pkg::*;

  logic [1:0] step_r, step_nxt;
  logic       xfer;

  assign out_valid = !status.empty;
  assign xfer      = out_valid && !out_stall;
  assign pop       = xfer && out_data.last;

  always_comb begin
    out_data.mem_offset = head_cmd.addr_a[14:0];
    out_data.mem_data   = head_cmd.addr_b[7:0];
    out_data.is_trailer = 1'b0;
    out_data.last       = 1'b1;
    case (head_cmd.kind)
      CMD_DATA: begin
      end
      CMD_TRAILER: begin
        out_data.mem_offset = TRAILER_OFS + 15'(step_r);
        out_data.is_trailer = 1'b1;
        out_data.last       = (step_r == 2'd3);
        case (step_r)
          2'd0:    out_data.mem_data = head_cmd.addr_a[7:0];
          2'd1:    out_data.mem_data = head_cmd.addr_a[15:8];
          2'd2:    out_data.mem_data = head_cmd.addr_b[7:0];
          default: out_data.mem_data = head_cmd.addr_b[15:8];
        endcase
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (xfer) begin
      step_nxt = out_data.last ? 2'd0 : step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

@@ src/hex_record_loader_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_record_loader_core
// Streams a hex-record file in by character and emits memory window writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one file character per
//   transfer, or a file_end marker. Output channel (out_valid / out_stall /
//   out_data) carries memory writes: offset, byte, trailer flag, last flag.
//   Throughput: one character per cycle while in_stall is low. A data write is
//   queued when the character that completes its byte is taken, and leaves on
//   out_data once it reaches the queue head. Finishing a load (zero-count
//   record or file_end) produces four trailer writes at 3ECh-3EFh; the command
//   queue absorbs them while characters keep flowing, and in_stall rises only
//   once the queue fills up (queue depth sets how long a trailer or an output
//   stall can be hidden).
//   When the receiver holds out_stall, the current write holds steady and
//   later writes wait in the queue; the parser keeps running until it is full.
//   Synchronous active-low reset returns the parser to the lead character of
//   a fresh load and empties the queue; in_stall is low right after reset.
//   A file_end transfer rearms the block for the next file.
// ----------------------------------------------------------------------------
`include "hex_record_loader_core_defines.svh"

module hex_record_loader_core #(
  parameter int unsigned WINDOW_BASE = hrl_pkg::WINDOW_BASE_DEF,
  parameter int unsigned MEM_SIZE    = hrl_pkg::MEM_SIZE_DEF,
  parameter int unsigned QUEUE_DEPTH = hrl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hrl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hrl_pkg::out_item_t out_data
);
  import hrl_pkg::*;

  logic      in_accept;
  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      head_cmd;
  q_status_t q_status;

  // Stall the sender only when the queue has no room left
  assign in_stall  = q_status.full;
  assign in_accept = in_valid && !in_stall;

  hrl_front #(
    .WINDOW_BASE (WINDOW_BASE),
    .MEM_SIZE    (MEM_SIZE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .item     (in_data),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Decouple parsing from emission so each side can stall on its own
  hrl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (q_status)
  );

  hrl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cmd  (head_cmd),
    .status    (q_status),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .pop       (pop)
  );

  // Plain data writes are always the single, last result of their character
  `HRL_ASSERT_NOW(a_data_is_last, out_valid && !out_data.is_trailer, out_data.last)
  // A trailer sequence, once started, continues with the next trailer write
  `HRL_ASSERT_NEXT(a_trailer_continues,
                   out_valid && !out_stall && out_data.is_trailer && !out_data.last,
                   out_valid && out_data.is_trailer)
  // Trailer writes land only in the trailer slots
  `HRL_ASSERT_NOW(a_trailer_offset, out_valid && out_data.is_trailer,
                  out_data.mem_offset[14:2] == TRAILER_OFS[14:2])
  // Only a pushed command can end the empty state
  `HRL_ASSERT_NEXT(a_no_phantom, q_status.empty && !push, !out_valid)

endmodule
